// ===== hw/rtl/bitmap_sort_dedup_core_defines.svh =====
// Assertion macros for the bitmap sort core.
// Included by the top level; has no other dependencies.
`ifndef BITMAP_SORT_DEDUP_CORE_DEFINES_SVH
`define BITMAP_SORT_DEDUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BSD_ASSERT_HOLDS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bsd: invariant violated");
`define BSD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsd: implication violated");
`define BSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsd: next-cycle check violated");
`else
`define BSD_ASSERT_HOLDS(label, clk, rst, cond)
`define BSD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/bsd_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package bsd_pkg;

  localparam int UNIVERSE   = 65536;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (UNIVERSE + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int VAL_W      = $clog2(UNIVERSE);
  localparam int SCAN_W     = VAL_W + 1;
  localparam int VALUE_W    = 32;
  localparam int OUT_W      = 16;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_NEXT   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_IGNORED = 3'd2;
  localparam logic [2:0] ST_EMITTED = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  typedef enum logic [2:0] {
    RES_INSERT,
    RES_FOUND,
    RES_DONE,
    RES_CLEARED,
    RES_IGNORED
  } res_kind_t;

  typedef struct packed {
    logic      rd_item;
    logic      rd_scan_start;
    logic      rd_scan_step;
    logic      wr_insert;
    logic      clr_start;
    logic      clr_write;
    logic      scan_reset;
    logic      scan_load;
    logic      load_result;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic scan_done;
    logic hit;
    logic last_word;
    logic clr_last;
  } stat_t;

endpackage

// ===== hw/rtl/bsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bsd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bsd_dpath.sv =====
// Datapath: presence bitmap RAM, scan pointer, clear sweep counter, result word.
// Depends on bsd_pkg and bsd_ram.
`timescale 1ns / 1ps

module bsd_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  bsd_pkg::cmd_t                cmd,
  output bsd_pkg::stat_t               stat,
  input  logic signed [bsd_pkg::VALUE_W-1:0] value,
  output logic [2:0]                   status,
  output logic [bsd_pkg::OUT_W-1:0]    sorted_value
);

  function automatic logic [bsd_pkg::BIT_W-1:0] lowest_index(
    input logic [bsd_pkg::WORD_BITS-1:0] w
  );
    logic [bsd_pkg::WORD_BITS-1:0] rest;
    logic [bsd_pkg::BIT_W-1:0]     idx;
    rest = w;
    idx  = '0;
    for (int i = bsd_pkg::BIT_W - 1; i >= 0; i--) begin
      if ((rest & ((bsd_pkg::WORD_BITS'(1) << (1 << i)) - bsd_pkg::WORD_BITS'(1))) == '0) begin
        idx[i] = 1'b1;
        rest   = rest >> (1 << i);
      end
    end
    return idx;
  endfunction

  logic                              ram_we;
  logic [bsd_pkg::ADDR_W-1:0]        ram_waddr;
  logic [bsd_pkg::WORD_BITS-1:0]     ram_wdata;
  logic                              ram_re;
  logic [bsd_pkg::ADDR_W-1:0]        ram_raddr;
  logic [bsd_pkg::WORD_BITS-1:0]     rdata;

  logic [bsd_pkg::SCAN_W-1:0]        scan_position;
  logic [bsd_pkg::ADDR_W-1:0]        clr_count;
  logic [bsd_pkg::ADDR_W-1:0]        item_word;
  logic [bsd_pkg::BIT_W-1:0]         item_bit;
  logic [bsd_pkg::ADDR_W-1:0]        cur_word;
  logic                              first;

  logic [bsd_pkg::ADDR_W-1:0]        scan_word;
  logic [bsd_pkg::BIT_W-1:0]         scan_bit;
  logic [bsd_pkg::WORD_BITS-1:0]     ins_mask;
  logic [bsd_pkg::WORD_BITS-1:0]     masked;
  logic [bsd_pkg::VAL_W-1:0]         found;
  logic                              dup;

  assign scan_word = scan_position[bsd_pkg::VAL_W-1:bsd_pkg::BIT_W];
  assign scan_bit  = scan_position[bsd_pkg::BIT_W-1:0];
  assign ins_mask  = bsd_pkg::WORD_BITS'(1) << item_bit;
  assign dup       = rdata[item_bit];

  // The first word of a scan drops bits below the pointer.
  assign masked = first ? (rdata & ({bsd_pkg::WORD_BITS{1'b1}} << scan_bit)) : rdata;
  assign found  = {cur_word, lowest_index(masked)};

  assign stat.in_range  = (value[bsd_pkg::VALUE_W-1:bsd_pkg::VAL_W] == '0);
  assign stat.scan_done = scan_position[bsd_pkg::SCAN_W-1];
  assign stat.hit       = |masked;
  assign stat.last_word = (cur_word == bsd_pkg::ADDR_W'(bsd_pkg::WORD_COUNT - 1));
  assign stat.clr_last  = (clr_count == bsd_pkg::ADDR_W'(bsd_pkg::WORD_COUNT - 1));

  always_comb begin
    ram_re    = cmd.rd_item | cmd.rd_scan_start | cmd.rd_scan_step;
    ram_raddr = cur_word + 1'b1;
    if (cmd.rd_item) begin
      ram_raddr = value[bsd_pkg::VAL_W-1:bsd_pkg::BIT_W];
    end else if (cmd.rd_scan_start) begin
      ram_raddr = scan_word;
    end
    ram_we    = cmd.wr_insert | cmd.clr_write;
    ram_waddr = cmd.clr_write ? clr_count : item_word;
    ram_wdata = cmd.clr_write ? '0 : (rdata | ins_mask);
  end

  bsd_ram #(
    .WIDTH (bsd_pkg::WORD_BITS),
    .DEPTH (bsd_pkg::WORD_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
      clr_count     <= '0;
    end else begin
      if (cmd.scan_reset) begin
        scan_position <= '0;
      end else if (cmd.scan_load) begin
        scan_position <= {1'b0, found} + 1'b1;
      end
      if (cmd.clr_start) begin
        clr_count <= '0;
      end else if (cmd.clr_write) begin
        clr_count <= clr_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_item) begin
      item_word <= value[bsd_pkg::VAL_W-1:bsd_pkg::BIT_W];
      item_bit  <= value[bsd_pkg::BIT_W-1:0];
    end
    if (cmd.rd_scan_start) begin
      cur_word <= scan_word;
      first    <= 1'b1;
    end else if (cmd.rd_scan_step) begin
      cur_word <= cur_word + 1'b1;
      first    <= 1'b0;
    end
    if (cmd.load_result) begin
      sorted_value <= (cmd.kind == bsd_pkg::RES_FOUND) ? bsd_pkg::OUT_W'(found) : '0;
      case (cmd.kind)
        bsd_pkg::RES_INSERT:  status <= dup ? bsd_pkg::ST_DUP : bsd_pkg::ST_NEW;
        bsd_pkg::RES_FOUND:   status <= bsd_pkg::ST_EMITTED;
        bsd_pkg::RES_DONE:    status <= bsd_pkg::ST_DONE;
        bsd_pkg::RES_CLEARED: status <= bsd_pkg::ST_CLEARED;
        default:              status <= bsd_pkg::ST_IGNORED;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bsd_ctrl.sv =====
// Controller: sequences insert, scan and clear operations and owns the result valid.
// Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  logic [1:0]     action,
  output logic           result_valid,
  input  logic           result_stall,
  input  bsd_pkg::stat_t stat,
  output bsd_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_RESPOND
  } state_t;

  state_t             state;
  state_t             state_next;
  bsd_pkg::res_kind_t kind;
  bsd_pkg::res_kind_t kind_next;
  logic               clr_pending;
  logic               clr_pending_next;
  logic               out_free;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd              = '0;
    cmd.kind         = kind;
    state_next       = state;
    kind_next        = kind;
    clr_pending_next = clr_pending;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          cmd.scan_reset = 1'b1;
          if (clr_pending) begin
            kind_next        = bsd_pkg::RES_CLEARED;
            clr_pending_next = 1'b0;
            state_next       = S_RESPOND;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          unique case (action)
            bsd_pkg::ACT_INSERT: begin
              if (stat.in_range) begin
                cmd.rd_item = 1'b1;
                state_next  = S_INSERT;
              end else begin
                kind_next  = bsd_pkg::RES_IGNORED;
                state_next = S_RESPOND;
              end
            end
            bsd_pkg::ACT_NEXT: begin
              if (stat.scan_done) begin
                kind_next  = bsd_pkg::RES_DONE;
                state_next = S_RESPOND;
              end else begin
                cmd.rd_scan_start = 1'b1;
                state_next        = S_SCAN;
              end
            end
            bsd_pkg::ACT_CLEAR: begin
              cmd.clr_start    = 1'b1;
              clr_pending_next = 1'b1;
              state_next       = S_CLEAR;
            end
            default: begin
              kind_next  = bsd_pkg::RES_IGNORED;
              state_next = S_RESPOND;
            end
          endcase
        end
      end
      S_INSERT: begin
        cmd.kind = bsd_pkg::RES_INSERT;
        if (out_free) begin
          cmd.wr_insert   = 1'b1;
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.kind = bsd_pkg::RES_FOUND;
        if (stat.hit) begin
          if (out_free) begin
            cmd.load_result = 1'b1;
            cmd.scan_load   = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (stat.last_word) begin
          kind_next  = bsd_pkg::RES_DONE;
          state_next = S_RESPOND;
        end else begin
          // advance to the next word
          cmd.rd_scan_step = 1'b1;
        end
      end
      S_RESPOND: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      kind         <= bsd_pkg::RES_IGNORED;
      clr_pending  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      kind         <= kind_next;
      clr_pending  <= clr_pending_next;
      result_valid <= cmd.load_result | (result_valid & result_stall);
    end
  end

endmodule

// ===== hw/rtl/bitmap_sort_dedup_core.sv =====
// Bitmap sort core: insert, out-of-range or unused action, next and clear operations.
// Next examines one 64-bit RAM word per cycle until a set bit is found, else reports done.
// Clear: accept, one RAM word zeroed per cycle, then the result.
// After reset a clearing pass over all WORD_COUNT (1024) words runs; no word is taken then.
// One word in flight at a time; the result register lets the next word be taken.
`timescale 1ns / 1ps
`include "bitmap_sort_dedup_core_defines.svh"

module bitmap_sort_dedup_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          action,
  input  logic signed [bsd_pkg::VALUE_W-1:0]  value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [2:0]                          status,
  output logic [bsd_pkg::OUT_W-1:0]           sorted_value
);

  bsd_pkg::cmd_t  cmd;
  bsd_pkg::stat_t stat;

  bsd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  bsd_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .value        (value),
    .status       (status),
    .sorted_value (sorted_value)
  );

  // a waiting result is never overwritten
  `BSD_ASSERT_HOLDS(a_no_overwrite, clk, rst, !(cmd.load_result && result_valid && result_stall))
  // no word is taken while the bitmap is being swept
  `BSD_ASSERT_IMPLIES(a_clear_blocks, clk, rst, cmd.clr_write, item_stall)
  // an insert write always goes out with its result, which shows up next cycle
  `BSD_ASSERT_NEXT(a_insert_result, clk, rst, cmd.wr_insert, result_valid)
  `BSD_ASSERT_IMPLIES(a_scan_emits, clk, rst, cmd.scan_load,
                      cmd.load_result && (cmd.kind == bsd_pkg::RES_FOUND))

endmodule
